@@ rtl/fwsps_pkg.sv @@
// shared types and port widths for the flash write stager page splitter
package fwsps_pkg;

  // flash page and staging buffer sizes in bytes
  localparam int PAGE_BYTES   = 512;
  localparam int BUFFER_BYTES = 4096;

  // widths of the result fields as they appear on the ports
  localparam int PAGE_COLUMN_W = 9;
  localparam int BYTE_COUNT_W  = 10;
  localparam int BUF_OFFSET_W  = 12;
  localparam int FILL_INDEX_W  = 13;
  localparam int PACKET_LEN_W  = 10;
  localparam int ADDR_W        = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic step;     // emit one page command and advance
    logic load;     // output register takes a new word
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic hit;        // accepted packet completes the staged block
    logic last_page;  // current page is the final one of the block
  } status_t;

endpackage

@@ rtl/fwsps_ctrl.sv @@
// controller: handshake, output word valid and flush sequencing
module fwsps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fwsps_pkg::status_t  sts,
  output fwsps_pkg::cmd_t     cmd
);

  typedef enum logic {
    S_IDLE,
    S_FLUSH
  } state_t;

  state_t state;
  logic   out_free;

  // output slot is free when empty or being drained this cycle
  always_comb begin
    out_free   = !out_valid || !out_stall;
    in_stall   = !(state == S_IDLE && out_free);
    cmd.accept = in_valid && !in_stall;
    cmd.step   = (state == S_FLUSH) && out_free;
    cmd.load   = (cmd.accept && !sts.hit) || cmd.step;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.accept && sts.hit) state <= S_FLUSH;
        end
        S_FLUSH: begin
          if (cmd.step && sts.last_page) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.load) out_valid <= 1'b1;
      else          out_valid <= out_valid && out_stall;
    end
  end

  // a completed block always starts a flush
  a_hit_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && sts.hit |=> state == S_FLUSH)
    else $error("block completion did not start a flush");

  // final page ends the flush
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.step && sts.last_page |=> state == S_IDLE)
    else $error("flush did not end after final page");

  // a pending word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(out_valid && out_stall))
    else $error("output word overwritten while stalled");

endmodule

@@ rtl/fwsps_datapath.sv @@
// datapath: request state, staging fill count and page command generation
module fwsps_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [fwsps_pkg::ADDR_W-1:0]           cfg_data,
  input  fwsps_pkg::cmd_t                        cmd,
  output fwsps_pkg::status_t                     sts,
  input  logic                                   new_request,
  input  logic [fwsps_pkg::ADDR_W-1:0]           byte_offset,
  input  logic [fwsps_pkg::ADDR_W-1:0]           request_length,
  input  logic [fwsps_pkg::PACKET_LEN_W-1:0]     packet_length,
  output logic                                   page_valid,
  output logic [fwsps_pkg::ADDR_W-1:0]           page_address,
  output logic [fwsps_pkg::PAGE_COLUMN_W-1:0]    page_column,
  output logic [fwsps_pkg::BYTE_COUNT_W-1:0]     byte_count,
  output logic [fwsps_pkg::BUF_OFFSET_W-1:0]     buffer_offset,
  output logic                                   read_modify_write,
  output logic [fwsps_pkg::FILL_INDEX_W-1:0]     next_fill_index,
  output logic                                   last
);

  localparam int AW = fwsps_pkg::ADDR_W;
  localparam int PW = $clog2(fwsps_pkg::PAGE_BYTES);
  localparam int BW = $clog2(fwsps_pkg::BUFFER_BYTES + 1);
  localparam int CW = (PW + 1 > BW) ? PW + 1 : BW;

  // block length chosen from what is left of the request
  function automatic logic [BW-1:0] pick_block(input logic [AW-1:0] rem);
    logic [BW-1:0] r;
    if (rem > AW'(fwsps_pkg::BUFFER_BYTES)) r = BW'(fwsps_pkg::BUFFER_BYTES);
    else                                    r = rem[BW-1:0];
    return r;
  endfunction

  logic [AW-1:0] disk_base;
  logic [AW-1:0] block_addr;
  logic [AW-1:0] remaining;
  logic [BW-1:0] block_length;
  logic [BW-1:0] fill_index;
  logic [BW-1:0] done;

  logic [AW-1:0] eff_addr;
  logic [AW-1:0] eff_rem;
  logic [BW-1:0] eff_blk;
  logic [BW-1:0] eff_fill;
  logic [BW:0]   sum;
  logic [BW-1:0] fill_sat;
  logic          blk_hit;

  logic [PW-1:0] poff;
  logic [PW:0]   chunk_full;
  logic [CW-1:0] chunk_c;
  logic [BW-1:0] chunk;
  logic [BW-1:0] size_left;
  logic [AW-1:0] rem_next;
  logic          page_last;

  // request values as seen by the packet being accepted
  always_comb begin
    eff_addr = new_request ? disk_base + byte_offset : block_addr;
    eff_rem  = new_request ? request_length : remaining;
    eff_blk  = new_request ? pick_block(request_length) : block_length;
    eff_fill = new_request ? '0 : fill_index;
    sum      = {1'b0, eff_fill} + (BW + 1)'(packet_length);
    if (sum > (BW + 1)'(fwsps_pkg::BUFFER_BYTES)) fill_sat = BW'(fwsps_pkg::BUFFER_BYTES);
    else                                          fill_sat = sum[BW-1:0];
    blk_hit  = (eff_blk != '0) && (eff_fill < eff_blk) && (sum == {1'b0, eff_blk});
  end

  // current page: up to the next page boundary, limited by what is left
  always_comb begin
    poff       = block_addr[PW-1:0];
    chunk_full = (PW + 1)'(fwsps_pkg::PAGE_BYTES) - {1'b0, poff};
    if (CW'(chunk_full) > CW'(block_length)) chunk_c = CW'(block_length);
    else                                     chunk_c = CW'(chunk_full);
    chunk     = BW'(chunk_c);
    size_left = block_length - chunk;
    rem_next  = remaining - AW'(chunk);
    page_last = (size_left == '0);
  end

  // status to the controller
  assign sts = '{hit: blk_hit, last_page: page_last};

  // request and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_base    <= '0;
      block_addr   <= '0;
      remaining    <= '0;
      block_length <= '0;
      fill_index   <= '0;
      done         <= '0;
    end else begin
      if (cfg_write) disk_base <= cfg_data;
      if (cmd.accept) begin
        block_addr   <= eff_addr;
        remaining    <= eff_rem;
        block_length <= eff_blk;
        fill_index   <= blk_hit ? '0 : fill_sat;
        done         <= '0;
      end else if (cmd.step) begin
        block_addr   <= block_addr + AW'(chunk);
        remaining    <= rem_next;
        block_length <= page_last ? pick_block(rem_next) : size_left;
        done         <= done + chunk;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.step) begin
        page_valid        <= 1'b1;
        page_address      <= block_addr & ~AW'(fwsps_pkg::PAGE_BYTES - 1);
        page_column       <= fwsps_pkg::PAGE_COLUMN_W'(poff);
        byte_count        <= fwsps_pkg::BYTE_COUNT_W'(chunk);
        buffer_offset     <= fwsps_pkg::BUF_OFFSET_W'(done);
        read_modify_write <= (CW'(chunk) < CW'(fwsps_pkg::PAGE_BYTES));
        next_fill_index   <= '0;
        last              <= page_last;
      end else begin
        page_valid        <= 1'b0;
        page_address      <= '0;
        page_column       <= '0;
        byte_count        <= '0;
        buffer_offset     <= '0;
        read_modify_write <= 1'b0;
        next_fill_index   <= fwsps_pkg::FILL_INDEX_W'(fill_sat);
        last              <= 1'b1;
      end
    end
  end

  // a page is only emitted while part of the block is still unwritten
  a_step_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> block_length != '0)
    else $error("page step with empty block");

endmodule

@@ rtl/flash_write_stager_page_splitter_unit.sv @@
// Top level: flash write stager page splitter.
// A packet word that leaves the block incomplete goes straight into the output register;
// one that completes it sets the flush state, and no packet is taken until the flush has
// emitted one page command per page (at most BUFFER_BYTES/PAGE_BYTES + 1 pages); the
// page sequencer hands one command per cycle to the single output register unless stalled.
// Reset (rst, synchronous): clears disk base, request state and fill index; no word pending.
module flash_write_stager_page_splitter_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [fwsps_pkg::ADDR_W-1:0]           cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   new_request,
  input  logic [fwsps_pkg::ADDR_W-1:0]           byte_offset,
  input  logic [fwsps_pkg::ADDR_W-1:0]           request_length,
  input  logic [fwsps_pkg::PACKET_LEN_W-1:0]     packet_length,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   page_valid,
  output logic [fwsps_pkg::ADDR_W-1:0]           page_address,
  output logic [fwsps_pkg::PAGE_COLUMN_W-1:0]    page_column,
  output logic [fwsps_pkg::BYTE_COUNT_W-1:0]     byte_count,
  output logic [fwsps_pkg::BUF_OFFSET_W-1:0]     buffer_offset,
  output logic                                   read_modify_write,
  output logic [fwsps_pkg::FILL_INDEX_W-1:0]     next_fill_index,
  output logic                                   last
);

  fwsps_pkg::cmd_t    cmd;
  fwsps_pkg::status_t sts;

  // sequencing and handshake
  fwsps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // request state and page arithmetic
  fwsps_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .sts               (sts),
    .new_request       (new_request),
    .byte_offset       (byte_offset),
    .request_length    (request_length),
    .packet_length     (packet_length),
    .page_valid        (page_valid),
    .page_address      (page_address),
    .page_column       (page_column),
    .byte_count        (byte_count),
    .buffer_offset     (buffer_offset),
    .read_modify_write (read_modify_write),
    .next_fill_index   (next_fill_index),
    .last              (last)
  );

endmodule

@@ tb/sv/fwsps_tb_pkg.sv @@
// page command tracker: shadow state of the page splitter and the queue of expected words
`timescale 1ns / 100ps

package fwsps_tb_pkg;

  import fwsps_pkg::*;

  localparam int unsigned PAGE_SIZE   = fwsps_pkg::PAGE_BYTES;
  localparam int unsigned STAGE_BYTES = fwsps_pkg::BUFFER_BYTES;

  // one result word as it leaves the block
  typedef struct packed {
    logic                     page_valid;
    logic [ADDR_W-1:0]        page_address;
    logic [PAGE_COLUMN_W-1:0] page_column;
    logic [BYTE_COUNT_W-1:0]  byte_count;
    logic [BUF_OFFSET_W-1:0]  buffer_offset;
    logic                     read_modify_write;
    logic [FILL_INDEX_W-1:0]  next_fill_index;
    logic                     last;
  } page_word_t;

  class page_split_tracker;

    // shadow copy of the request state
    bit [ADDR_W-1:0]       disk_base;
    bit [ADDR_W-1:0]       block_addr;
    bit [ADDR_W-1:0]       remaining;
    bit [FILL_INDEX_W-1:0] block_len;
    bit [FILL_INDEX_W-1:0] fill;

    page_word_t expected_pages[$];

    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned flushes;

    function new();
      clear();
    endfunction

    function void clear();
      disk_base  = '0;
      block_addr = '0;
      remaining  = '0;
      block_len  = '0;
      fill       = '0;
      expected_pages.delete();
      mismatches    = 0;
      words_checked = 0;
      flushes       = 0;
    endfunction

    function void write_base(bit [ADDR_W-1:0] value);
      disk_base = value;
    endfunction

    // staging block is the remaining length capped at the buffer size
    function bit [FILL_INDEX_W-1:0] block_size(bit [ADDR_W-1:0] rem);
      return (rem > STAGE_BYTES) ? FILL_INDEX_W'(STAGE_BYTES) : FILL_INDEX_W'(rem);
    endfunction

    // accepted packet word: advance the fill index, split the block into pages on a hit
    function void take_packet(bit nr, bit [ADDR_W-1:0] off, bit [ADDR_W-1:0] len,
                              bit [PACKET_LEN_W-1:0] plen);
      page_word_t      w;
      int unsigned     sum;
      int unsigned     size;
      int unsigned     done;
      int unsigned     poff;
      int unsigned     chunk;
      bit [ADDR_W-1:0] a;

      if (nr) begin
        block_addr = disk_base + off;
        remaining  = len;
        block_len  = block_size(len);
        fill       = '0;
      end
      sum = fill + plen;
      w   = '0;

      // no hit: one word with the new fill index, saturated at the buffer size
      if (block_len == 0 || fill >= block_len || sum != block_len) begin
        fill              = (sum > STAGE_BYTES) ? FILL_INDEX_W'(STAGE_BYTES) : FILL_INDEX_W'(sum);
        w.next_fill_index = fill;
        w.last            = 1'b1;
        expected_pages.push_back(w);
        return;
      end

      // hit: head page, full pages, tail page, in address order
      flushes++;
      a    = block_addr;
      size = block_len;
      done = 0;
      while (size > 0) begin
        poff  = a[8:0];
        chunk = PAGE_SIZE - poff;
        if (chunk > size)
          chunk = size;
        size -= chunk;
        w.page_valid        = 1'b1;
        w.page_address      = a - poff;
        w.page_column       = PAGE_COLUMN_W'(poff);
        w.byte_count        = BYTE_COUNT_W'(chunk);
        w.buffer_offset     = BUF_OFFSET_W'(done);
        w.read_modify_write = (chunk < PAGE_SIZE);
        w.next_fill_index   = '0;
        w.last              = (size == 0);
        expected_pages.push_back(w);
        done += chunk;
        a    += chunk;
      end

      block_addr = block_addr + block_len;
      remaining  = remaining - block_len;
      block_len  = block_size(remaining);
      fill       = '0;
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // result word against the oldest expectation
    function void match_word(page_word_t got);
      page_word_t want;
      words_checked++;
      if (expected_pages.size() == 0) begin
        $error("result word with nothing expected (page_address 0x%0h)", got.page_address);
        mismatches++;
        return;
      end
      want = expected_pages.pop_front();
      compare_field("page_valid", want.page_valid, got.page_valid);
      compare_field("page_address", want.page_address, got.page_address);
      compare_field("page_column", want.page_column, got.page_column);
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("buffer_offset", want.buffer_offset, got.buffer_offset);
      compare_field("read_modify_write", want.read_modify_write, got.read_modify_write);
      compare_field("next_fill_index", want.next_fill_index, got.next_fill_index);
      compare_field("last", want.last, got.last);
    endfunction

  endclass

endpackage

@@ tb/sv/flash_write_stager_page_splitter_unit_tb.sv @@
// testbench top: drives packet words and disk base settings, checks page command and fill index words
`timescale 1ns / 100ps

module flash_write_stager_page_splitter_unit_tb;

  import fwsps_pkg::*;
  import fwsps_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned DIRECTED    = 25;
  localparam int unsigned PER_PHASE   = 70;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [ADDR_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     new_request = 1'b0;
  logic [ADDR_W-1:0]        byte_offset = '0;
  logic [ADDR_W-1:0]        request_length = '0;
  logic [PACKET_LEN_W-1:0]  packet_length = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     page_valid;
  logic [ADDR_W-1:0]        page_address;
  logic [PAGE_COLUMN_W-1:0] page_column;
  logic [BYTE_COUNT_W-1:0]  byte_count;
  logic [BUF_OFFSET_W-1:0]  buffer_offset;
  logic                     read_modify_write;
  logic [FILL_INDEX_W-1:0]  next_fill_index;
  logic                     last;

  page_split_tracker tracker;
  int unsigned       cycles = 0;
  int unsigned       sent = 0;
  int unsigned       base_writes = 0;
  int unsigned       stall_left = 0;
  bit                quiet = 1'b0;

  flash_write_stager_page_splitter_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .new_request      (new_request),
    .byte_offset      (byte_offset),
    .request_length   (request_length),
    .packet_length    (packet_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .page_valid       (page_valid),
    .page_address     (page_address),
    .page_column      (page_column),
    .byte_count       (byte_count),
    .buffer_offset    (buffer_offset),
    .read_modify_write(read_modify_write),
    .next_fill_index  (next_fill_index),
    .last             (last)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               tracker.expected_pages.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // gap lengths: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_stall  = (stall_left != 0);
      if (stall_left != 0)
        stall_left--;
    end
  end

  // sample both handshakes at the rising edge; inputs noted before outputs are checked
  always @(posedge clk) begin : monitor
    page_word_t got;
    if (!rst) begin
      if (in_valid && !in_stall)
        tracker.take_packet(new_request, byte_offset, request_length, packet_length);
      if (out_valid && !out_stall) begin
        got.page_valid        = page_valid;
        got.page_address      = page_address;
        got.page_column       = page_column;
        got.byte_count        = byte_count;
        got.buffer_offset     = buffer_offset;
        got.read_modify_write = read_modify_write;
        got.next_fill_index   = next_fill_index;
        got.last              = last;
        tracker.match_word(got);
      end
    end
  end

  // one packet word, held until taken; called and returns at a falling edge
  task automatic send_word(input bit nr, input bit [ADDR_W-1:0] off,
                           input bit [ADDR_W-1:0] len, input bit [PACKET_LEN_W-1:0] plen);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    new_request    = nr;
    byte_offset    = off;
    request_length = len;
    packet_length  = plen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // idle the sender until every expected word has come out
  task automatic drain();
    in_valid = 1'b0;
    while (tracker.expected_pages.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_disk_base(input bit [ADDR_W-1:0] value);
    drain();
    cfg_write = 1'b1;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    tracker.write_base(value);
    base_writes++;
  endtask

  // a write request split into packets; broken ones stop early or overshoot the block
  task automatic run_request(input bit broken);
    bit [ADDR_W-1:0] off;
    bit [ADDR_W-1:0] len;
    bit [ADDR_W-1:0] rem;
    int unsigned     blen;
    int unsigned     fill;
    int unsigned     p;
    int unsigned     cut;
    int unsigned     ov;
    int unsigned     style;
    int unsigned     r;
    int unsigned     nblk;
    bit              first;

    off = $urandom;
    if ($urandom_range(0, 3) == 0)
      off[8:0] = '0;
    r = $urandom_range(0, 19);
    if (r < 12)
      len = $urandom_range(1, 2048);
    else if (r < 17)
      len = $urandom_range(2049, 9000);
    else if (r < 19)
      len = $urandom_range(1, 16) * PAGE_SIZE;
    else
      len = $urandom | 32'h1;

    rem   = len;
    first = 1'b1;
    nblk  = 0;
    while (rem != 0 && nblk < 3) begin
      blen  = (rem > STAGE_BYTES) ? STAGE_BYTES : rem;
      fill  = 0;
      style = $urandom_range(0, 2);
      cut   = broken ? $urandom_range(0, blen - 1) : blen;
      while (fill < blen) begin
        if (style == 0)
          p = PAGE_SIZE;
        else if (style == 1)
          p = $urandom_range(1, PAGE_SIZE);
        else
          p = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(16, PAGE_SIZE);
        if (fill + p > blen)
          p = blen - fill;
        if (broken && fill + p >= cut) begin
          // either abandon the request or push past the end of the block
          ov = blen - fill + $urandom_range(1, 64);
          if ($urandom_range(0, 1) == 0 && ov <= PAGE_SIZE)
            send_word(first, first ? off : $urandom, first ? len : $urandom,
                      PACKET_LEN_W'(ov));
          return;
        end
        send_word(first, first ? off : $urandom, first ? len : $urandom, PACKET_LEN_W'(p));
        first = 1'b0;
        fill += p;
      end
      rem -= blen;
      nblk++;
    end
  endtask

  // random words with random request fields
  task automatic send_noise();
    bit [ADDR_W-1:0] len;
    len = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 600);
    send_word($urandom_range(0, 1), $urandom, len, PACKET_LEN_W'($urandom_range(0, PAGE_SIZE)));
  endtask

  initial begin
    int unsigned     r;
    bit [ADDR_W-1:0] base;

    tracker = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       base = '0;
        1:       base = '1;
        3:       base = 32'hFFFF_F000;
        4:       base = 32'h0000_0200;
        default: base = $urandom;
      endcase
      write_disk_base(base);

      if (phase == 0) begin
        // packets with no request open, request fields all zeros or all ones but unused
        send_word(1'b0, '0, '0, 10'd512);
        send_word(1'b0, '1, '1, 10'd0);
        // one full page
        send_word(1'b1, 32'd0, 32'd512, 10'd512);
        // head page, full page, tail page
        send_word(1'b1, 32'd100, 32'd1000, 10'd500);
        send_word(1'b0, '0, '0, 10'd500);
        // largest block, nine pages, address wraps past the top
        send_word(1'b1, 32'hFFFF_FF00, 32'hFFFF_FFFF, 10'd512);
        repeat (7) send_word(1'b0, '0, '0, 10'd512);
        // overshoot, then no flush until the next request
        send_word(1'b1, 32'd0, 32'd10, 10'd512);
        send_word(1'b0, '0, '0, 10'd0);
        // single byte block
        send_word(1'b1, 32'd0, 32'd1, 10'd1);
        // empty block, fill index runs up to saturation
        send_word(1'b1, 32'd0, 32'd0, 10'd512);
        repeat (8) send_word(1'b0, '0, '0, 10'd512);
      end

      while (sent < DIRECTED + (phase + 1) * PER_PHASE) begin
        if ($urandom_range(0, 9) == 0)
          quiet = !quiet;
        r = $urandom_range(0, 99);
        if (r < 70)
          run_request(1'b0);
        else if (r < 85)
          run_request(1'b1);
        else
          repeat ($urandom_range(1, 4)) send_noise();
      end
    end

    drain();
    repeat (16) @(negedge clk);

    $display("%0d packet words over %0d disk base settings", sent, base_writes);
    $display("%0d result words checked, %0d blocks split into pages",
             tracker.words_checked, tracker.flushes);
    if (tracker.mismatches == 0 && tracker.expected_pages.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
